### sv/kui_pkg.sv
// Package for the k-mer uniqueness indexer: sizes, table tag codes,
// payload structs, outcome codes and the table-side state type. No dependencies.
`timescale 1ns / 1ps
package kui_pkg;

  localparam int KMER_LENGTH   = 8;
  localparam int POSITION_BITS = 28;
  localparam int CODE_BITS     = 2 * KMER_LENGTH;
  localparam int TOTAL_BITS    = CODE_BITS + 1;
  localparam int RUN_BITS      = $clog2(KMER_LENGTH + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NBASE       = 8'h4E;
  localparam logic [7:0] TAG_UNSET   = 8'hFF;
  localparam logic [7:0] TAG_REPEAT  = 8'h00;
  localparam logic [7:0] TAG_ZERO_ID = 8'h80;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [1:0] {
    OUT_NONE           = 2'd0,
    OUT_FIRST          = 2'd1,
    OUT_BECAME_REPEAT  = 2'd2,
    OUT_ALREADY_REPEAT = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_LOOKUP
  } back_state_t;

  typedef struct packed {
    logic [7:0] base;
    logic [6:0] seq_id;
    logic       seq_start;
  } in_item_t;

  typedef struct packed {
    logic                     kmer_valid;
    logic [CODE_BITS-1:0]     kmer_code;
    logic [POSITION_BITS-1:0] start_pos;
    outcome_t                 outcome;
    logic [TOTAL_BITS-1:0]    unique_total;
    logic [TOTAL_BITS-1:0]    repeat_total;
  } out_item_t;

  // Classified item passed from the front to the table side.
  typedef struct packed {
    logic                     kmer_valid;
    logic [CODE_BITS-1:0]     kmer_code;
    logic [POSITION_BITS-1:0] start_pos;
    logic [7:0]               tag;
  } kmer_item_t;

endpackage

### sv/kui_front.sv
// Front of the k-mer uniqueness indexer: window, run length and position.
// Classifies each base into a k-mer item. Depends on kui_pkg.
`timescale 1ns / 1ps
module kui_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  kui_pkg::in_item_t in_data,
  input  logic              hold,
  output logic              in_stall,
  output logic              push,
  output kui_pkg::kmer_item_t item
);
  import kui_pkg::*;

  logic [CODE_BITS-1:0]     window_r, window_nxt;
  logic [RUN_BITS-1:0]      run_r, run_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic [CODE_BITS-1:0]     w0;
  logic [RUN_BITS-1:0]      r0, run_inc;
  logic [POSITION_BITS-1:0] p0;

  assign in_stall = hold;
  assign push     = in_valid && !hold;

  always_comb begin
    w0 = in_data.seq_start ? '0 : window_r;
    r0 = in_data.seq_start ? '0 : run_r;
    p0 = in_data.seq_start ? '0 : pos_r;
    pos_nxt = (p0 < POS_MAX) ? p0 + 1'b1 : p0;
    run_inc = (r0 < RUN_BITS'(KMER_LENGTH)) ? r0 + 1'b1 : r0;
    item = '0;
    if (in_data.base == NBASE) begin
      window_nxt = w0;
      run_nxt    = '0;
    end else begin
      window_nxt = {in_data.base[2:1], w0[CODE_BITS-1:2]};
      run_nxt    = run_inc;
      if (run_inc == RUN_BITS'(KMER_LENGTH)) begin
        item.kmer_valid = 1'b1;
        item.kmer_code  = window_nxt;
        item.start_pos  = (p0 >= POSITION_BITS'(KMER_LENGTH - 1)) ?
                          p0 - POSITION_BITS'(KMER_LENGTH - 1) : '0;
      end
    end
    item.tag = (in_data.seq_id != 7'd0) ? {1'b0, in_data.seq_id} : TAG_ZERO_ID;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      run_r    <= '0;
      pos_r    <= '0;
    end else if (push) begin
      window_r <= window_nxt;
      run_r    <= run_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

### sv/kui_queue.sv
// Short queue between the front and the table side of the indexer.
// Holds classified k-mer items. Depends on kui_pkg.
`timescale 1ns / 1ps
module kui_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kui_pkg::kmer_item_t push_data,
  input  logic                pop,
  output kui_pkg::kmer_item_t pop_data,
  output logic                full,
  output logic                empty
);
  import kui_pkg::*;

  kmer_item_t           slots_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/kui_back.sv
// Table side of the indexer: tag memory read-modify-write, totals and the
// result register, plus the clearing pass after reset. Depends on kui_pkg.
`timescale 1ns / 1ps
module kui_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  kui_pkg::kmer_item_t q_data,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output kui_pkg::out_item_t  out_data
);
  import kui_pkg::*;

  logic [7:0] tag_mem [1 << CODE_BITS];

  back_state_t           state_r, state_nxt;
  logic [CODE_BITS-1:0]  clr_addr_r, clr_addr_nxt;
  kmer_item_t            hold_r, hold_nxt;
  logic [7:0]            rdata_r;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0] uniq_r, uniq_nxt, rep_r, rep_nxt;

  logic                  mem_we, mem_re;
  logic [CODE_BITS-1:0]  mem_waddr;
  logic [7:0]            mem_wdata;
  logic                  slot_free;

  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    uniq_nxt      = uniq_r;
    rep_nxt       = rep_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = hold_r.kmer_code;
    mem_wdata     = TAG_UNSET;
    q_pop         = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {CODE_BITS{1'b1}}) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_data.kmer_valid) begin
            mem_re    = 1'b1;
            hold_nxt  = q_data;
            state_nxt = BK_LOOKUP;
          end else begin
            out_nxt       = '{kmer_valid: 1'b0, kmer_code: '0, start_pos: '0,
                              outcome: OUT_NONE, unique_total: uniq_r,
                              repeat_total: rep_r};
            out_valid_nxt = 1'b1;
          end
        end
      end
      BK_LOOKUP: begin
        // The result slot was freed when this item left the queue.
        out_nxt.kmer_valid = 1'b1;
        out_nxt.kmer_code  = hold_r.kmer_code;
        out_nxt.start_pos  = hold_r.start_pos;
        if (rdata_r == TAG_UNSET) begin
          mem_we          = 1'b1;
          mem_wdata       = hold_r.tag;
          uniq_nxt        = uniq_r + 1'b1;
          out_nxt.outcome = OUT_FIRST;
        end else if (rdata_r != TAG_REPEAT) begin
          mem_we          = 1'b1;
          mem_wdata       = TAG_REPEAT;
          uniq_nxt        = (uniq_r != '0) ? uniq_r - 1'b1 : uniq_r;
          rep_nxt         = rep_r + 1'b1;
          out_nxt.outcome = OUT_BECAME_REPEAT;
        end else begin
          out_nxt.outcome = OUT_ALREADY_REPEAT;
        end
        out_nxt.unique_total = uniq_nxt;
        out_nxt.repeat_total = rep_nxt;
        out_valid_nxt        = 1'b1;
        state_nxt            = BK_RUN;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      uniq_r      <= '0;
      rep_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      uniq_r      <= uniq_nxt;
      rep_r       <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= tag_mem[q_data.kmer_code];
    end
  end

endmodule

### sv/kmer_uniqueness_indexer_top.sv
// K-mer uniqueness indexer top level. Each base passes the queue and the result register;
// a base that ends a k-mer also passes the table lookup state before its result is shown.
// While the result register is free, the table side can take a new base after one without
// a k-mer, but not during a k-mer lookup: the tag table is read on the pop and written then.
// Reset: synchronous active-low; afterwards a clearing pass over all 2^(2*KMER_LENGTH)
// entries (65536) sets every table entry unset while no input transfer is taken.
`timescale 1ns / 1ps
module kmer_uniqueness_indexer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kui_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kui_pkg::out_item_t out_data
);
  import kui_pkg::*;

  // The front tracks the sliding window, the run of non-N bases and the position
  // within the sequence, and turns each transfer into a classified item.
  kmer_item_t f_item;
  kmer_item_t q_item;
  logic       f_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       clearing;
  logic       front_hold;

  // The front holds off new transfers while the queue is full or the table is
  // still being cleared after reset.
  assign front_hold = q_full || clearing;

  kui_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .hold     (front_hold),
    .in_stall (in_stall),
    .push     (f_push),
    .item     (f_item)
  );

  // The queue decouples the front from the table side, so each can stall on its own.
  kui_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_item),
    .pop       (q_pop),
    .pop_data  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The table side looks up each k-mer, updates its tag and the totals, and
  // places the result in an output register that parts it from the consumer.
  kui_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
